>>> sv/pfba_pkg.sv
// ----------------------------------------------------------------------------
// pfba_pkg
// Shared constants, types and helpers of the phase-fold bin averager.
// ----------------------------------------------------------------------------
package pfba_pkg;

	localparam int MAX_BINS    = 64;
	localparam int MAX_SAMPLES = 65536;
	localparam int BIN_W       = $clog2(MAX_BINS);

	localparam int CNT_W  = 17;
	localparam int SUM_W  = 39;
	localparam int SQ_W   = 59;
	localparam int MAG_W  = 22;
	localparam int NB_W   = 7;
	localparam int EPO_W  = 54;
	localparam int FRQ_W  = 50;
	localparam int PH_W   = 16;
	localparam int SE_W   = 22;

	localparam logic [NB_W-1:0] MIN_BINS = NB_W'(5);
	localparam logic [SE_W-1:0] SE_MAX   = {SE_W{1'b1}};

	// Result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_SINGLE = 2'd2;

	// Configuration register indexes (byte address = 8 * index)
	localparam logic [1:0] REG_BIN_COUNT = 2'd0;
	localparam logic [1:0] REG_EPOCH     = 2'd1;
	localparam logic [1:0] REG_FREQUENCY = 2'd2;

	typedef struct packed {
		logic        [CNT_W-1:0] cnt;
		logic signed [SUM_W-1:0] sum;
		logic        [SQ_W-1:0]  sq;
	} pfba_entry_t;

	typedef struct packed {
		pfba_entry_t      ent;
		logic [BIN_W-1:0] idx;
		logic [NB_W-1:0]  nbins;
	} pfba_stat_req_t;

	typedef struct packed {
		logic [MAG_W-1:0] mean;
		logic [SE_W-1:0]  se;
		logic [PH_W-1:0]  phase;
		logic [1:0]       status;
	} pfba_stat_res_t;

	// Clamp the programmed bin count into the supported range.
	function automatic logic [NB_W-1:0] active_bins(input logic [NB_W-1:0] bc);
		logic [NB_W-1:0] n;
		n = bc;
		if (n < MIN_BINS) n = MIN_BINS;
		if (n > NB_W'(MAX_BINS)) n = NB_W'(MAX_BINS);
		return n;
	endfunction

endpackage

>>> sv/pfba_phase.sv
// ----------------------------------------------------------------------------
// pfba_phase
// Folds a time into a phase and picks its bin.
// ----------------------------------------------------------------------------
module pfba_phase (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pfba_pkg::EPO_W-1:0]   obs_time,
	input  logic [pfba_pkg::EPO_W-1:0]   epoch,
	input  logic [pfba_pkg::FRQ_W-1:0]   frequency,
	input  logic [pfba_pkg::NB_W-1:0]    nbins,
	output logic                         done,
	output logic [pfba_pkg::BIN_W-1:0]   bin
);
	import pfba_pkg::*;

	logic [2:0]       step_q;
	logic             neg_q;
	logic [53:0]      d_q;
	logic [71:0]      acc_q;
	logic [79:0]      prod_q;
	logic             done_q;
	logic [BIN_W-1:0] bin_q;

	logic [26:0] pa;
	logic [24:0] pb;
	logic [6:0]  sh;
	logic [51:0] pp;
	logic [8:0]  c;
	logic [7:0]  j;

	always_comb begin
		pa = d_q[26:0];
		pb = frequency[24:0];
		sh = 7'd0;
		case (step_q)
			3'd2: begin
				pb = frequency[49:25];
				sh = 7'd25;
			end
			3'd3: begin
				pa = d_q[53:27];
				sh = 7'd27;
			end
			3'd4: begin
				pa = d_q[53:27];
				pb = frequency[49:25];
				sh = 7'd52;
			end
			default: ;
		endcase
		pp = 52'(pa) * 52'(pb);
		c  = 9'(prod_q[79:72]) + 9'(|prod_q[71:0]);
		j  = c[8:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (step_q == 3'd0) begin
				if (start) step_q <= 3'd1;
			end else if (step_q == 3'd7) begin
				step_q <= 3'd0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_q == 3'd0 && start) begin
			neg_q <= obs_time < epoch;
			d_q   <= (obs_time < epoch) ? epoch - obs_time : obs_time - epoch;
			acc_q <= '0;
		end else if (step_q >= 3'd1 && step_q <= 3'd4) begin
			acc_q <= acc_q + (72'(pp) << sh);
		end else if (step_q == 3'd5) begin
			// negative offsets fold from the top of the cycle
			if (neg_q) acc_q <= ~acc_q + 72'd1;
		end else if (step_q == 3'd6) begin
			prod_q <= 80'(acc_q) * 80'({nbins, 1'b0});
		end else if (step_q == 3'd7) begin
			bin_q <= (j >= 8'(nbins)) ? '0 : j[BIN_W-1:0];
		end
	end

	assign done = done_q;
	assign bin  = bin_q;

endmodule

>>> sv/pfba_stat.sv
// ----------------------------------------------------------------------------
// pfba_stat
// Per-bin statistics: phase, mean and standard error through one shared
// restoring divider, a serial multiplier and a bit-pair square root.
// ----------------------------------------------------------------------------
module pfba_stat (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  pfba_pkg::pfba_stat_req_t req,
	output logic                     done,
	output pfba_pkg::pfba_stat_res_t res
);
	import pfba_pkg::*;

	localparam int DIV_W = 76;
	localparam int DSR_W = 51;

	localparam logic [3:0] SS_IDLE  = 4'd0;
	localparam logic [3:0] SS_PH    = 4'd1;
	localparam logic [3:0] SS_MEAN  = 4'd2;
	localparam logic [3:0] SS_MULA  = 4'd3;
	localparam logic [3:0] SS_MULB  = 4'd4;
	localparam logic [3:0] SS_DEN1  = 4'd5;
	localparam logic [3:0] SS_DEN2  = 4'd6;
	localparam logic [3:0] SS_SUB   = 4'd7;
	localparam logic [3:0] SS_SEDIV = 4'd8;
	localparam logic [3:0] SS_SQRT  = 4'd9;

	logic [3:0]       state_q;
	logic [6:0]       it_q;
	logic             done_q;
	pfba_stat_res_t   res_q;
	pfba_stat_req_t   req_q;
	logic             neg_q;
	logic [SUM_W-1:0] mag_q;

	logic [DIV_W-1:0] num_q, quo_q, a_q;
	logic [DSR_W:0]   rem_q;
	logic [DSR_W-1:0] dsr_q, den_q;
	logic [33:0]      cc_q;
	logic [77:0]      acc_q, mcand_q;
	logic [SUM_W-1:0] mplier_q;
	logic [63:0]      v_q, root_q, bit_q;

	logic [DSR_W:0]   rem_sh, rem_n;
	logic             ge;
	logic [DIV_W-1:0] quo_n;
	logic [77:0]      acc_n;
	logic [63:0]      trial;
	logic [MAG_W-1:0] qm;

	always_comb begin
		rem_sh = {rem_q[DSR_W-1:0], num_q[DIV_W-1]};
		ge     = rem_sh >= {1'b0, dsr_q};
		rem_n  = ge ? rem_sh - {1'b0, dsr_q} : rem_sh;
		quo_n  = {quo_q[DIV_W-2:0], ge};
		acc_n  = acc_q + (mplier_q[0] ? mcand_q : 78'd0);
		trial  = root_q + bit_q;
		qm     = quo_n[MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SS_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				SS_IDLE:  if (start) state_q <= SS_PH;
				SS_PH: if (it_q == '0) begin
					if (req_q.ent.cnt == '0) begin
						state_q <= SS_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= SS_MEAN;
					end
				end
				SS_MEAN: if (it_q == '0) begin
					if (req_q.ent.cnt == CNT_W'(1)) begin
						state_q <= SS_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= SS_MULA;
					end
				end
				SS_MULA:  if (it_q == '0) state_q <= SS_MULB;
				SS_MULB:  if (it_q == '0) state_q <= SS_DEN1;
				SS_DEN1:  state_q <= SS_DEN2;
				SS_DEN2:  state_q <= SS_SUB;
				SS_SUB: begin
					if ({2'b0, a_q} < acc_q) begin
						state_q <= SS_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= SS_SEDIV;
					end
				end
				SS_SEDIV: if (it_q == '0) begin
					if (quo_n[DIV_W-1:64] != '0) begin
						state_q <= SS_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= SS_SQRT;
					end
				end
				SS_SQRT: if (it_q == '0) begin
					state_q <= SS_IDLE;
					done_q  <= 1'b1;
				end
				default:  state_q <= SS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SS_IDLE: if (start) begin
				req_q        <= req;
				neg_q        <= req.ent.sum < 0;
				mag_q        <= (req.ent.sum < 0) ? -req.ent.sum : req.ent.sum;
				res_q.mean   <= '0;
				res_q.se     <= '0;
				res_q.status <= (req.ent.cnt == '0) ? ST_EMPTY :
					(req.ent.cnt == CNT_W'(1)) ? ST_SINGLE : ST_OK;
				// bin centre: (j * 2^17 + n) / 2n
				num_q        <= DIV_W'({req.idx, 17'd0}) + DIV_W'(req.nbins);
				dsr_q        <= DSR_W'({req.nbins, 1'b0});
				rem_q        <= '0;
				quo_q        <= '0;
				it_q         <= 7'(DIV_W - 1);
			end
			SS_PH, SS_MEAN, SS_SEDIV: begin
				num_q <= num_q << 1;
				rem_q <= rem_n;
				quo_q <= quo_n;
				it_q  <= it_q - 7'd1;
				if (it_q == '0) begin
					if (state_q == SS_PH) begin
						res_q.phase <= quo_n[PH_W-1:0];
						num_q       <= DIV_W'(mag_q) + DIV_W'(req_q.ent.cnt[CNT_W-1:1]);
						dsr_q       <= DSR_W'(req_q.ent.cnt);
						rem_q       <= '0;
						quo_q       <= '0;
						it_q        <= 7'(DIV_W - 1);
					end else if (state_q == SS_MEAN) begin
						res_q.mean <= neg_q ? -qm : qm;
						mcand_q    <= 78'(req_q.ent.sq);
						mplier_q   <= SUM_W'(req_q.ent.cnt);
						acc_q      <= '0;
						it_q       <= 7'(CNT_W - 1);
					end else if (quo_n[DIV_W-1:64] != '0) begin
						res_q.se <= SE_MAX;
					end else begin
						v_q    <= quo_n[63:0];
						root_q <= '0;
						bit_q  <= 64'd1 << 62;
						it_q   <= 7'd31;
					end
				end
			end
			SS_MULA, SS_MULB: begin
				acc_q    <= acc_n;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				it_q     <= it_q - 7'd1;
				if (it_q == '0 && state_q == SS_MULA) begin
					a_q      <= acc_n[DIV_W-1:0];
					acc_q    <= '0;
					mcand_q  <= 78'(mag_q);
					mplier_q <= mag_q;
					it_q     <= 7'(SUM_W - 1);
				end
			end
			SS_DEN1: cc_q  <= 34'(req_q.ent.cnt) * 34'(req_q.ent.cnt);
			SS_DEN2: den_q <= DSR_W'(cc_q) * DSR_W'(req_q.ent.cnt - CNT_W'(1));
			SS_SUB: begin
				num_q <= a_q - acc_q[DIV_W-1:0];
				dsr_q <= den_q;
				rem_q <= '0;
				quo_q <= '0;
				it_q  <= 7'(DIV_W - 1);
			end
			SS_SQRT: begin
				if (v_q >= trial) begin
					v_q    <= v_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
				it_q  <= it_q - 7'd1;
				if (it_q == '0) begin
					if (v_q >= trial)
						res_q.se <= (((root_q >> 1) + bit_q) > 64'(SE_MAX)) ? SE_MAX :
							SE_W'((root_q >> 1) + bit_q);
					else
						res_q.se <= ((root_q >> 1) > 64'(SE_MAX)) ? SE_MAX :
							SE_W'(root_q >> 1);
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

>>> sv/phase_fold_bin_averager_top.sv
// ----------------------------------------------------------------------------
// phase_fold_bin_averager_top
// Epoch-folding phase binner with per-bin mean and standard error.
// ----------------------------------------------------------------------------
// One command is taken at a time: start is honored only while busy is low.
// An accumulate command (cmd 0) runs through the phase unit, which folds the
// time through four 27x25 partial products; the bin memory is read as the
// unit signals done, the bin is written back, and the block returns to idle,
// where the next start is taken. A finish command
// (cmd 1) walks bins 0..n-1
// and emits one result per bin on result_strobe; each bin goes through the
// shared 76-step divider (bin phase, mean, variance quotient), the serial
// multiplier and the 32-step square root, an empty bin stopping after the
// phase and a bin with one sample after the mean. The receiver cannot stall:
// every result is present for exactly one cycle. Finish clears all bins at
// once through per-bin valid flags, as does reset; no clearing pass is run.
// Configuration goes through the APB port (64-bit data, registers at byte
// addresses 0, 8 and 16) and must only be written while busy is low.
// ----------------------------------------------------------------------------
module phase_fold_bin_averager_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// command channel
	input  logic                                start,
	output logic                                busy,
	input  logic                                cmd,
	input  logic [pfba_pkg::EPO_W-1:0]          obs_time,
	input  logic signed [pfba_pkg::MAG_W-1:0]   mag,
	// result channel
	output logic                                result_strobe,
	output logic [pfba_pkg::BIN_W-1:0]          bin_index,
	output logic [pfba_pkg::PH_W-1:0]           bin_phase,
	output logic signed [pfba_pkg::MAG_W-1:0]   mean_mag,
	output logic [pfba_pkg::SE_W-1:0]           std_error,
	output logic [pfba_pkg::CNT_W-1:0]          sample_count,
	output logic [1:0]                          bin_status,
	output logic                                last,
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [4:0]                          paddr,
	input  logic [63:0]                         pwdata,
	output logic [63:0]                         prdata,
	output logic                                pready
);
	import pfba_pkg::*;

	localparam logic [2:0] T_IDLE   = 3'd0;
	localparam logic [2:0] T_PHASE  = 3'd1;
	localparam logic [2:0] T_MOD    = 3'd2;
	localparam logic [2:0] T_FRD    = 3'd3;
	localparam logic [2:0] T_FSTART = 3'd4;
	localparam logic [2:0] T_FWAIT  = 3'd5;

	// configuration registers
	logic [NB_W-1:0]  bin_count_q;
	logic [EPO_W-1:0] epoch_q;
	logic [FRQ_W-1:0] frequency_q;
	logic             cfg_wr;
	logic [NB_W-1:0]  nbins;

	// control
	logic [2:0]             state_q;
	logic [BIN_W-1:0]       idx_q;
	logic [BIN_W-1:0]       bin_q;
	logic signed [MAG_W-1:0] mag_q;
	logic [43:0]            sq_s1;

	// bin memory: one entry per bin, read data registered
	pfba_entry_t            mem [MAX_BINS];
	pfba_entry_t            rd_q;
	logic [MAX_BINS-1:0]    valid_q;
	logic                   vrd_q;
	logic                   rd_en, wr_en, clr_all;
	logic [BIN_W-1:0]       rd_addr;
	pfba_entry_t            ent, upd;

	// units
	logic                   ph_start, ph_done;
	logic [BIN_W-1:0]       ph_bin;
	logic                   st_start, st_done;
	pfba_stat_req_t         st_req;
	pfba_stat_res_t         st_res;

	// result registers
	logic                   strobe_q, last_q;
	logic [BIN_W-1:0]       idx_out_q;
	logic [CNT_W-1:0]       cnt_out_q;
	pfba_stat_res_t         res_q;

	logic                   accept;

	assign accept = start && !busy;
	assign busy   = state_q != T_IDLE;
	assign nbins  = active_bins(bin_count_q);

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q <= NB_W'(30);
			epoch_q     <= '0;
			frequency_q <= FRQ_W'(64'd1099511627776);
		end else if (cfg_wr) begin
			unique case (paddr[4:3])
				REG_BIN_COUNT: bin_count_q <= pwdata[NB_W-1:0];
				REG_EPOCH:     epoch_q     <= pwdata[EPO_W-1:0];
				REG_FREQUENCY: frequency_q <= pwdata[FRQ_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			REG_BIN_COUNT: prdata = 64'(bin_count_q);
			REG_EPOCH:     prdata = 64'(epoch_q);
			REG_FREQUENCY: prdata = 64'(frequency_q);
			default:       prdata = '0;
		endcase
	end

	// ---------------- phase unit ----------------
	assign ph_start = accept && !cmd;

	pfba_phase u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ph_start),
		.obs_time  (obs_time),
		.epoch     (epoch_q),
		.frequency (frequency_q),
		.nbins     (nbins),
		.done      (ph_done),
		.bin       (ph_bin)
	);

	// ---------------- bin memory ----------------
	// Read the bin when its index is known; an entry never written since the
	// last clear reads as zero through its valid flag.
	assign rd_en   = (state_q == T_PHASE && ph_done) || state_q == T_FRD;
	assign rd_addr = (state_q == T_PHASE) ? ph_bin : idx_q;
	assign ent     = vrd_q ? rd_q : '0;

	always_comb begin
		upd.cnt = ent.cnt + CNT_W'(1);
		upd.sum = ent.sum + SUM_W'(mag_q);
		upd.sq  = ent.sq + SQ_W'(sq_s1);
	end

	// Drop the sample once its bin is full.
	assign wr_en   = state_q == T_MOD && ent.cnt < CNT_W'(MAX_SAMPLES);
	assign clr_all = state_q == T_FWAIT && st_done && idx_q == BIN_W'(nbins - NB_W'(1));

	always_ff @(posedge clk) begin
		if (wr_en) mem[bin_q] <= upd;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vrd_q   <= 1'b0;
		end else begin
			if (clr_all) valid_q <= '0;
			else if (wr_en) valid_q[bin_q] <= 1'b1;
			if (rd_en) vrd_q <= valid_q[rd_addr];
		end
	end

	// ---------------- statistics unit ----------------
	assign st_start    = state_q == T_FSTART;
	assign st_req.ent  = ent;
	assign st_req.idx  = idx_q;
	assign st_req.nbins = nbins;

	pfba_stat u_stat (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (st_start),
		.req    (st_req),
		.done   (st_done),
		.res    (st_res)
	);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= T_IDLE;
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				T_IDLE: if (accept) begin
					idx_q   <= '0;
					state_q <= cmd ? T_FRD : T_PHASE;
				end
				T_PHASE:  if (ph_done) state_q <= T_MOD;
				T_MOD:    state_q <= T_IDLE;
				T_FRD:    state_q <= T_FSTART;
				T_FSTART: state_q <= T_FWAIT;
				T_FWAIT: if (st_done) begin
					// emit this bin, then advance or finish the walk
					strobe_q <= 1'b1;
					if (clr_all) begin
						state_q <= T_IDLE;
					end else begin
						idx_q   <= idx_q + BIN_W'(1);
						state_q <= T_FRD;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !cmd) mag_q <= mag;
		if (state_q == T_PHASE) begin
			sq_s1 <= 44'(mag_q) * 44'(mag_q);
			if (ph_done) bin_q <= ph_bin;
		end
		if (state_q == T_FSTART) cnt_out_q <= ent.cnt;
		if (state_q == T_FWAIT && st_done) begin
			res_q     <= st_res;
			idx_out_q <= idx_q;
			last_q    <= clr_all;
		end
	end

	assign result_strobe = strobe_q;
	assign bin_index     = idx_out_q;
	assign bin_phase     = res_q.phase;
	assign mean_mag      = res_q.mean;
	assign std_error     = res_q.se;
	assign sample_count  = cnt_out_q;
	assign bin_status    = res_q.status;
	assign last          = last_q;

`ifndef NO_ASSERTIONS
	a_strobe_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> $past(state_q == T_FWAIT))
		else $error("result strobe outside the finish walk");
	a_last_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && last_q |-> !busy)
		else $error("final bin emitted while still busy");
	a_write_no_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && clr_all))
		else $error("bin write collides with clear");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("command taken but block not busy");
`endif

endmodule
